// ----- hw/rtl/bdq_pkg.sv -----
// Shared types and command and error codes for the bounded deque.
package bdq_pkg;

  localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [2:0] CMD_POP_BACK   = 3'd3;
  localparam logic [2:0] CMD_READ       = 3'd4;

  localparam logic [1:0] ERR_OK        = 2'd0;
  localparam logic [1:0] ERR_EMPTY     = 2'd1;
  localparam logic [1:0] ERR_FULL      = 2'd2;
  localparam logic [1:0] ERR_BAD_INDEX = 2'd3;

  typedef struct packed {
    logic push_front;
    logic pop_front;
  } shift_op_t;

endpackage

// ----- hw/rtl/bdq_cell.sv -----
// One storage cell of the deque chain, shifting toward either neighbor.
module bdq_cell #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  bdq_pkg::shift_op_t    op,
  input  logic                  load_en,
  input  logic                  rd_sel,
  input  logic [DATA_WIDTH-1:0] load_word,
  input  logic [DATA_WIDTH-1:0] left_word,
  input  logic [DATA_WIDTH-1:0] right_word,
  output logic [DATA_WIDTH-1:0] word_q,
  output logic [DATA_WIDTH-1:0] rd_word
);

  logic [DATA_WIDTH-1:0] word_r;

  always_ff @(posedge clk) begin
    if (op.push_front) begin
      word_r <= left_word;
    end else if (op.pop_front) begin
      word_r <= right_word;
    end else if (load_en) begin
      word_r <= load_word;
    end
  end

  assign word_q  = word_r;
  assign rd_word = rd_sel ? word_r : '0;

endmodule

// ----- hw/rtl/bounded_deque_with_index_read.sv -----
// Top level of the bounded deque: command decode, fill count and the cell chain.
//
// A command word (in_cmd, in_value, in_position) is taken at a rising edge of clk
// where start is high and busy is low. busy stays low, so a new command may be
// given in every cycle. Each command yields one result word on the next cycle:
// out_valid is high for exactly that one cycle with out_data, out_error,
// out_count and out_empty_res. Throughput is one command per cycle, and the
// front entry always sits in cell zero.
// A push at the front shifts every cell toward the back, a pop at the front
// shifts every cell toward the front, a push at the back loads the cell just
// past the last entry, and reads select one cell by position.
// A rejected command leaves the state unchanged and reports its error code.
// Reset (rst_n low at a clock edge) empties the deque and clears the strobe;
// the cell contents are not cleared, since no entry is read before it is written.
// The receiver cannot stall; results must be taken in the cycle they appear.
module bounded_deque_with_index_read #(
  parameter int CAPACITY   = 32,
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_cmd,
  input  logic [31:0] in_value,
  input  logic [4:0]  in_position,
  output logic        out_valid,
  output logic [31:0] out_data,
  output logic [1:0]  out_error,
  output logic [5:0]  out_count,
  output logic        out_empty_res
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0] count_r, count_nxt;
  logic          out_valid_r;
  logic [31:0]   out_data_r;
  logic [1:0]    out_error_r;
  logic [5:0]    out_count_r;
  logic          out_empty_r;

  logic                  accept;
  logic                  full;
  logic                  empty;
  bdq_pkg::shift_op_t    op;
  logic                  load_back;
  logic                  rd_en;
  logic [IW-1:0]         rd_idx;
  logic [1:0]            err;
  logic [63:0]           value_ext;
  logic [DATA_WIDTH-1:0] value_w;
  logic [DATA_WIDTH-1:0] rd_word;
  logic [63:0]           rd_ext;

  logic [DATA_WIDTH-1:0] cell_q  [CAPACITY];
  logic [DATA_WIDTH-1:0] cell_rd [CAPACITY];

  assign busy      = 1'b0;
  assign accept    = start && !busy;
  assign full      = (count_r == CW'(CAPACITY));
  assign empty     = (count_r == '0);
  assign value_ext = {32'b0, in_value};
  assign value_w   = value_ext[DATA_WIDTH-1:0];

  always_comb begin
    op.push_front = 1'b0;
    op.pop_front  = 1'b0;
    load_back     = 1'b0;
    rd_en         = 1'b0;
    rd_idx        = '0;
    err           = bdq_pkg::ERR_OK;
    count_nxt     = count_r;
    case (in_cmd)
      bdq_pkg::CMD_PUSH_FRONT: begin
        if (full) begin
          err = bdq_pkg::ERR_FULL;
        end else begin
          op.push_front = accept;
          count_nxt     = count_r + CW'(1);
        end
      end
      bdq_pkg::CMD_PUSH_BACK: begin
        if (full) begin
          err = bdq_pkg::ERR_FULL;
        end else begin
          load_back = accept;
          count_nxt = count_r + CW'(1);
        end
      end
      bdq_pkg::CMD_POP_FRONT: begin
        if (empty) begin
          err = bdq_pkg::ERR_EMPTY;
        end else begin
          op.pop_front = accept;
          rd_en        = 1'b1;
          count_nxt    = count_r - CW'(1);
        end
      end
      bdq_pkg::CMD_POP_BACK: begin
        if (empty) begin
          err = bdq_pkg::ERR_EMPTY;
        end else begin
          rd_en     = 1'b1;
          rd_idx    = IW'(count_r - CW'(1));
          count_nxt = count_r - CW'(1);
        end
      end
      bdq_pkg::CMD_READ: begin
        if (32'(in_position) >= 32'(count_r)) begin
          err = bdq_pkg::ERR_BAD_INDEX;
        end else begin
          rd_en  = 1'b1;
          rd_idx = IW'(in_position);
        end
      end
      default: begin
      end
    endcase
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_w;
    logic [DATA_WIDTH-1:0] right_w;
    if (i == 0) begin : g_first
      assign left_w = value_w;
    end else begin : g_mid_l
      assign left_w = cell_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_q[i+1];
    end
    bdq_cell #(
      .DATA_WIDTH(DATA_WIDTH)
    ) u_cell (
      .clk       (clk),
      .op        (op),
      .load_en   (load_back && (count_r[IW-1:0] == IW'(i))),
      .rd_sel    (rd_en && (rd_idx == IW'(i))),
      .load_word (value_w),
      .left_word (left_w),
      .right_word(right_w),
      .word_q    (cell_q[i]),
      .rd_word   (cell_rd[i])
    );
  end

  always_comb begin
    rd_word = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_word = rd_word | cell_rd[i];
    end
  end

  assign rd_ext = 64'($signed(rd_word));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r  <= rd_ext[31:0];
      out_error_r <= err;
      out_count_r <= 6'(count_nxt);
      out_empty_r <= (count_nxt == '0);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;
  assign out_error     = out_error_r;
  assign out_count     = out_count_r;
  assign out_empty_res = out_empty_r;

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("accepted command gave no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> !out_valid)
    else $error("result without a command");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= 32'(CAPACITY))
    else $error("fill count beyond capacity");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_empty_res == (out_count == 6'd0)))
    else $error("empty flag disagrees with count");

endmodule
